// File: rtl/umcol_pkg.sv
// Shared types and codes for the min-cost open list.
package umcol_pkg;

    localparam int OP_W     = 2;
    localparam int NODE_W   = 16;
    localparam int COST_W   = 32;
    localparam int EPOCH_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

endpackage

// File: rtl/umcol_if.sv
// Handshake interfaces for the request and result channels.
interface umcol_in_if;
    logic                        valid;
    logic                        ready;
    logic [umcol_pkg::OP_W-1:0]    op;
    logic [umcol_pkg::NODE_W-1:0]  node_id;
    logic [umcol_pkg::COST_W-1:0]  cost;
    logic [umcol_pkg::EPOCH_W-1:0] epoch;

    modport source (output valid, op, node_id, cost, epoch, input ready);
    modport sink   (input valid, op, node_id, cost, epoch, output ready);
endinterface

interface umcol_out_if;
    logic                         valid;
    logic                         ready;
    logic [umcol_pkg::NODE_W-1:0]   node_out;
    logic [umcol_pkg::STATUS_W-1:0] status;
    logic [umcol_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, node_out, status, occupancy, input ready);
    modport sink   (input valid, node_out, status, occupancy, output ready);
endinterface

// File: rtl/unsorted_min_cost_open_list.sv
// Min-cost open list: a ring of DEPTH cells rotated past a head comparator.
//
// Usage: requests arrive on i_in (op, node_id, cost, epoch); every request
// gives exactly one result item on o_out (node_out, status, occupancy).
// Push appends a node, clearing the list first when the epoch changes.
// Pop returns the lowest-cost node (lowest slot on ties); remove deletes the
// first slot holding node_id. Both refill the freed slot with the last entry.
//
// Timing: in the scan and write states the entry ring rotates one cell per
// cycle past the head cell. Pop and a remove that hits take a scan turn and
// a write turn; a missing remove takes a scan turn, a push a write turn. A pop
// on an empty list, a push to a full list, an empty remove and the unused op
// are answered at acceptance. One request is worked at a time; the next is
// taken once the result is in the output register and that register frees up.
//
// Reset clears the fill count, the epoch and the output valid; the cells
// need no clearing. A stalled receiver holds the result in the output
// register; a finished request waits until the register frees up.
module unsorted_min_cost_open_list #(
    parameter int DEPTH       = 1024,
    parameter int HANDLE_BITS = 16,
    parameter int COST_BITS   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    umcol_in_if.sink     i_in,
    umcol_out_if.source  o_out
);
    import umcol_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_OUT} t_state;

    logic [HANDLE_BITS-1:0] w_cell_h [DEPTH];
    logic [COST_BITS-1:0]   w_cell_c [DEPTH];
    logic [HANDLE_BITS-1:0] w_tail_h;
    logic [COST_BITS-1:0]   w_tail_c;
    logic                   w_shift;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_k;
    logic [CNT_W-1:0]       r_fill;
    logic [EPOCH_W-1:0]     r_epoch;
    t_op                    r_op;
    logic [HANDLE_BITS-1:0] r_node;
    logic                   r_hit;
    logic [CNT_W-1:0]       r_best_idx;
    logic [COST_BITS-1:0]   r_best_c;
    logic [HANDLE_BITS-1:0] r_best_h;
    logic [HANDLE_BITS-1:0] r_last_h;
    logic [COST_BITS-1:0]   r_last_c;
    logic [CNT_W-1:0]       r_wr_idx;
    logic [HANDLE_BITS-1:0] r_wr_h;
    logic [COST_BITS-1:0]   r_wr_c;
    logic [NODE_W-1:0]      r_res_node;
    t_status                r_res_status;
    logic                   r_out_valid;
    logic [NODE_W-1:0]      r_out_node;
    t_status                r_out_status;
    logic [OCC_W-1:0]       r_out_occ;

    logic                   n_hit;
    logic [CNT_W-1:0]       n_best_idx;
    logic [COST_BITS-1:0]   n_best_c;
    logic [HANDLE_BITS-1:0] n_best_h;
    logic [HANDLE_BITS-1:0] n_last_h;
    logic [COST_BITS-1:0]   n_last_c;

    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_new_epoch;
    logic [CNT_W-1:0]       w_fill_eff;
    logic [31:0]            w_in_node32;
    logic [31:0]            w_in_cost32;
    logic [31:0]            w_best_h32;
    logic [31:0]            w_fill32;
    logic [HANDLE_BITS-1:0] w_in_h;
    logic [COST_BITS-1:0]   w_in_c;
    logic                   w_last_step;
    logic                   w_imm_done;
    logic                   w_out_load;

    assign w_shift = (r_state == S_SCAN) || (r_state == S_WRITE);

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        if (j == DEPTH - 1) begin : g_tail
            umcol_cell #(.HW(HANDLE_BITS), .CW(COST_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_shift),
                .i_handle (w_tail_h),
                .i_cost   (w_tail_c),
                .o_handle (w_cell_h[j]),
                .o_cost   (w_cell_c[j])
            );
        end else begin : g_mid
            umcol_cell #(.HW(HANDLE_BITS), .CW(COST_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_shift),
                .i_handle (w_cell_h[j+1]),
                .i_cost   (w_cell_c[j+1]),
                .o_handle (w_cell_h[j]),
                .o_cost   (w_cell_c[j])
            );
        end
    end

    // head cell wraps to the tail, replaced at the write slot
    always_comb begin
        if ((r_state == S_WRITE) && (r_k == r_wr_idx)) begin
            w_tail_h = r_wr_h;
            w_tail_c = r_wr_c;
        end else begin
            w_tail_h = w_cell_h[0];
            w_tail_c = w_cell_c[0];
        end
    end

    assign w_in_node32 = 32'(i_in.node_id);
    assign w_in_cost32 = 32'(i_in.cost);
    assign w_in_h      = w_in_node32[HANDLE_BITS-1:0];
    assign w_in_c      = w_in_cost32[COST_BITS-1:0];
    assign w_best_h32  = 32'(n_best_h);
    assign w_fill32    = 32'(r_fill);
    assign w_last_step = (r_k == CNT_W'(DEPTH - 1));

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_new_epoch = (i_in.epoch != r_epoch);
    assign w_fill_eff  = w_new_epoch ? '0 : r_fill;

    // item answered at acceptance
    assign w_imm_done  = (t_op'(i_in.op) == OP_PUSH) ? (w_fill_eff == CNT_W'(DEPTH)) :
                         ((t_op'(i_in.op) == OP_REMOVE) || (t_op'(i_in.op) == OP_POP)) ?
                         (r_fill == '0) : 1'b1;
    assign w_out_load  = ((r_state == S_IDLE) && w_accept && w_imm_done) ||
                         ((r_state == S_OUT) && w_out_free);

    always_comb begin
        n_hit      = r_hit;
        n_best_idx = r_best_idx;
        n_best_c   = r_best_c;
        n_best_h   = r_best_h;
        n_last_h   = r_last_h;
        n_last_c   = r_last_c;
        if (r_k < r_fill) begin
            if (r_k == r_fill - CNT_W'(1)) begin
                n_last_h = w_cell_h[0];
                n_last_c = w_cell_c[0];
            end
            if (r_op == OP_POP) begin
                if ((r_k == '0) || (w_cell_c[0] < r_best_c)) begin
                    n_best_idx = r_k;
                    n_best_c   = w_cell_c[0];
                    n_best_h   = w_cell_h[0];
                end
            end else if (!r_hit && (w_cell_h[0] == r_node)) begin
                n_hit      = 1'b1;
                n_best_idx = r_k;
            end
        end
    end

    assign i_in.ready = (r_state == S_IDLE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_epoch     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= t_op'(i_in.op);
                        r_node <= w_in_h;
                        r_k    <= '0;
                        r_hit  <= 1'b0;
                        r_out_node   <= '0;
                        r_out_status <= ST_OK;
                        r_out_occ    <= w_fill32[OCC_W-1:0];
                        unique case (t_op'(i_in.op))
                            OP_PUSH: begin
                                if (w_new_epoch) begin
                                    r_epoch <= i_in.epoch;
                                    r_fill  <= '0;
                                end
                                if (w_fill_eff == CNT_W'(DEPTH)) begin
                                    r_out_status <= ST_FULL;
                                end else begin
                                    r_wr_idx <= w_fill_eff;
                                    r_wr_h   <= w_in_h;
                                    r_wr_c   <= w_in_c;
                                    r_state  <= S_WRITE;
                                end
                            end
                            OP_REMOVE: begin
                                if (r_fill == '0) begin
                                    r_out_status <= ST_MISS;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            OP_POP: begin
                                if (r_fill == '0) begin
                                    r_out_status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_hit      <= n_hit;
                    r_best_idx <= n_best_idx;
                    r_best_c   <= n_best_c;
                    r_best_h   <= n_best_h;
                    r_last_h   <= n_last_h;
                    r_last_c   <= n_last_c;
                    r_k        <= w_last_step ? '0 : r_k + CNT_W'(1);
                    if (w_last_step) begin
                        r_wr_idx <= n_best_idx;
                        r_wr_h   <= n_last_h;
                        r_wr_c   <= n_last_c;
                        if ((r_op == OP_POP) || n_hit) begin
                            r_res_node   <= (r_op == OP_POP) ? w_best_h32[NODE_W-1:0] : '0;
                            r_res_status <= ST_OK;
                            r_state      <= S_WRITE;
                        end else begin
                            r_res_node   <= '0;
                            r_res_status <= ST_MISS;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_WRITE: begin
                    r_k <= w_last_step ? '0 : r_k + CNT_W'(1);
                    if (w_last_step) begin
                        if (r_op == OP_PUSH) begin
                            r_fill       <= r_fill + CNT_W'(1);
                            r_res_node   <= '0;
                            r_res_status <= ST_OK;
                        end else begin
                            r_fill <= r_fill - CNT_W'(1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_node   <= r_res_node;
                        r_out_status <= r_res_status;
                        r_out_occ    <= w_fill32[OCC_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.node_out  = r_out_node;
    assign o_out.status    = r_out_status;
    assign o_out.occupancy = r_out_occ;
endmodule

// File: rtl/umcol_cell.sv
// One storage cell of the rotating entry ring.
module umcol_cell #(
    parameter int HW = 16,
    parameter int CW = 32
) (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic [HW-1:0] i_handle,
    input  logic [CW-1:0] i_cost,
    output logic [HW-1:0] o_handle,
    output logic [CW-1:0] o_cost
);
    logic [HW-1:0] r_handle;
    logic [CW-1:0] r_cost;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_handle <= i_handle;
            r_cost   <= i_cost;
        end
    end

    assign o_handle = r_handle;
    assign o_cost   = r_cost;
endmodule
